FILE: sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Shared types, register map and codes for the allocator block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int NUM_BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF     = 16;
  localparam int BLOCK_COUNT_RESET = 16;

  // Configuration bus: two 32-bit registers at byte addresses 0 and 4.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_POLICY      = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Placement rules; the unused code behaves as first fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  block_index;
    logic [15:0] size;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  block_number;
    logic [15:0] remaining;
  } rsp_t;

  typedef struct packed {
    logic [1:0] policy;
    logic [4:0] block_count;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/fpba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/fpba_cfg.sv
// ----------------------------------------------------------------------------
// Allocator configuration registers
// Bus-facing policy and block count registers with read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpba_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [fpba_pkg::DATA_W-1:0]   pwdata,
  output logic      [fpba_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output fpba_pkg::cfg_t                     cfg
);

  import fpba_pkg::*;

  logic [1:0] policy;
  logic [4:0] block_count;
  logic       reg_sel;

  assign reg_sel = paddr[ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POL_FIRST;
      block_count <= 5'(BLOCK_COUNT_RESET);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_POLICY:      policy      <= pwdata[1:0];
        REG_BLOCK_COUNT: block_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POLICY:      prdata = DATA_W'(policy);
      REG_BLOCK_COUNT: prdata = DATA_W'(block_count);
      default:         prdata = '0;
    endcase
  end

  assign cfg.policy      = policy;
  assign cfg.block_count = block_count;

endmodule

`default_nettype wire

FILE: sv/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Takes items, scans the free-size table and writes the loaded or chosen entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ctrl #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
  localparam int NW = ($clog2(NUM_BLOCKS + 1) > 5) ? $clog2(NUM_BLOCKS + 1) : 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fpba_pkg::cfg_t       cfg,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire fpba_pkg::req_t       req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output fpba_pkg::rsp_t            rsp,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [SIZE_BITS-1:0]      mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  wire logic [SIZE_BITS-1:0] mem_rdata
);

  import fpba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t               state;
  logic [SIZE_BITS-1:0] sz;
  logic [NW-1:0]        iss;
  logic                 chk_valid;
  logic [AW-1:0]        chk_idx;
  logic                 found;
  logic [AW-1:0]        pick;
  logic [SIZE_BITS-1:0] best;

  // Result staged for the output register and the write-back.
  logic                 st_wr;
  logic [AW-1:0]        st_addr;
  logic [SIZE_BITS-1:0] st_data;
  logic                 st_granted;
  logic [3:0]           st_block;

  logic [SIZE_BITS-1:0] req_sz;
  logic                 idx_ok;
  logic [NW-1:0]        bc;
  logic [NW-1:0]        n;
  logic                 first;
  logic                 fits;
  logic [SIZE_BITS-1:0] left;
  logic                 better;
  logic                 take;
  logic                 scan_end;
  logic                 issue;
  logic                 slot_free;

  always_comb begin
    req_sz = SIZE_BITS'(req.size);
    idx_ok = NW'(req.block_index) < NW'(NUM_BLOCKS);
    bc     = NW'(cfg.block_count);
    n      = (bc > NW'(NUM_BLOCKS)) ? NW'(NUM_BLOCKS) : bc;
    first  = !(cfg.policy == POL_BEST || cfg.policy == POL_WORST);
    fits   = sz <= mem_rdata;
    left   = mem_rdata - sz;
    better = (cfg.policy == POL_BEST) ? (left < best) : (left > best);
    // Under first fit the first block that fits ends the scan.
    take   = chk_valid && fits && (first ? !found : (!found || better));
    scan_end  = (first && found) || (iss == n && !chk_valid);
    issue     = (state == ST_SCAN) && (iss != n) && !(first && found);
    slot_free = !rsp_valid || !rsp_stall;
  end

  assign req_stall = (state != ST_IDLE);
  assign mem_raddr = iss[AW-1:0];
  assign mem_we    = (state == ST_DONE) && slot_free && st_wr;
  assign mem_waddr = st_addr;
  assign mem_wdata = st_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      // A finishing item refills the output register in the same cycle.
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            sz <= req_sz;
            if (req.mode == MODE_LOAD) begin
              st_wr      <= idx_ok;
              st_addr    <= AW'(req.block_index);
              st_data    <= req_sz;
              st_granted <= 1'b0;
              st_block   <= req.block_index;
              state      <= ST_DONE;
            end else begin
              iss       <= '0;
              found     <= 1'b0;
              chk_valid <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          chk_valid <= issue;
          chk_idx   <= iss[AW-1:0];
          if (issue) begin
            iss <= iss + NW'(1);
          end
          if (take) begin
            found <= 1'b1;
            pick  <= chk_idx;
            best  <= left;
          end
          if (scan_end) begin
            st_wr      <= found;
            st_addr    <= pick;
            st_data    <= best;
            st_granted <= found;
            st_block   <= found ? 4'(pick) : 4'd0;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            rsp_valid        <= 1'b1;
            rsp.granted      <= st_granted;
            rsp.block_number <= st_block;
            rsp.remaining    <= st_wr ? 16'(st_data) : 16'd0;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Free-size table with first, best and worst fit placement of requests.
// ----------------------------------------------------------------------------
// An item on req either loads the free size of one block (mode load) or asks
// for an allocation of the given size (mode alloc). Each item yields exactly
// one item on rsp: the loaded block on a load, the chosen block and its
// leftover on a grant, or granted low on no fit. The policy and block count
// registers are written over the APB-style port; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// A load passes from idle through the done state to the output register. A
// request reads the table through the single read port of the RAM one entry
// a cycle, over the n blocks in use (the block count, capped at NUM_BLOCKS).
// First fit ends the scan at the first block that fits. No new item is
// accepted until the last one has left the done state. The result is held
// in an output register; the next item is accepted while it waits, but a
// finished item waits in the block until rsp is free, and req_stall stays
// high meanwhile. Reset clears the control state, the valid flags and the
// configuration registers; the table holds nothing usable until each block
// in use is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire fpba_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output fpba_pkg::rsp_t                   rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fpba_pkg::ADDR_W-1:0] paddr,
  input  wire logic [fpba_pkg::DATA_W-1:0] pwdata,
  output logic      [fpba_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  import fpba_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  cfg_t                 cfg;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [SIZE_BITS-1:0] mem_rdata;

  fpba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire
